>>> src/dielectric_refract_or_reflect_unit_assert.svh
// Assertion macros for the dielectric unit
`ifndef DIELECTRIC_REFRACT_OR_REFLECT_UNIT_ASSERT_SVH
`define DIELECTRIC_REFRACT_OR_REFLECT_UNIT_ASSERT_SVH

// condition holds at every edge outside reset
`define DRDR_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent now, consequent at the next edge
`define DRDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/drdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package drdr_pkg;

    localparam int SQRT_LAT = 8;

    localparam logic [1:0] REG_INDEX      = 2'd0;
    localparam logic [1:0] REG_TINT_RED   = 2'd1;
    localparam logic [1:0] REG_TINT_GREEN = 2'd2;
    localparam logic [1:0] REG_TINT_BLUE  = 2'd3;

    localparam logic [13:0] INDEX_RESET   = 14'd6144;
    localparam logic [17:0] RECIP_RESET   = 18'd43690;
    localparam logic [15:0] TINT_RESET    = 16'hFFFF;
    localparam logic [17:0] ETA_MAX       = 18'h3FFFF;
    localparam logic [13:0] INDEX_SAT     = 14'd1025;
    localparam logic [4:0]  DIV_LAST      = 5'd28;

    localparam logic signed [33:0] COS_MAX = 34'sd268435456;
    localparam logic [56:0]        ONE56   = 57'd1 << 56;
    localparam logic [61:0]        ONE56_W = 62'd1 << 56;
    localparam logic signed [67:0] HALF44  = 68'sd1 <<< 43;
    localparam logic signed [50:0] HALF28  = 51'sd1 <<< 27;
    localparam logic signed [23:0] DIR_MAX = 24'sd16384;

    typedef struct packed {
        logic                valid;
        logic [2:0][15:0]    d;
        logic [2:0][15:0]    n;
        logic [17:0]         eta;
        logic [2:0][15:0]    col;
        logic [2:0][31:0]    p;
        logic signed [32:0]  dn;
        logic signed [29:0]  cosv;
        logic [56:0]         rad;
        logic [28:0]         sinv;
        logic [46:0]         prod;
        logic                refr;
        logic signed [48:0]  ec;
        logic [56:0]         k;
        logic [2:0][50:0]    rfl;
        logic [28:0]         r;
        logic signed [49:0]  coef;
        logic [2:0][34:0]    ed;
        logic [2:0][65:0]    cn;
    } item_t;

    function automatic logic [15:0] tint_mul(input logic [15:0] c, input logic [15:0] t);
        logic [31:0] pr;
        pr = {16'd0, c} * {16'd0, t};
        pr = pr + 32'h0000_8000;
        return pr[31:16];
    endfunction

    function automatic logic [15:0] sat_dir(input logic signed [23:0] v);
        logic signed [23:0] s;
        s = v;
        if (v > DIR_MAX)
            s = DIR_MAX;
        else if (v < -DIR_MAX)
            s = -DIR_MAX;
        return s[15:0];
    endfunction

endpackage

`default_nettype wire

>>> src/drdr_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module drdr_isqrt
    import drdr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] value,
    output logic [28:0] root
);

    localparam int STEPS = 4;

    logic [35:0] rem_reg  [SQRT_LAT];
    logic [31:0] root_reg [SQRT_LAT];
    logic [63:0] val_reg  [SQRT_LAT];

    logic [35:0] rem_next  [SQRT_LAT];
    logic [31:0] root_next [SQRT_LAT];
    logic [63:0] val_next  [SQRT_LAT];

    for (genvar j = 0; j < SQRT_LAT; j++)
    begin : g_stage
        always_comb
        begin
            logic [35:0] rm;
            logic [31:0] rt;
            logic [63:0] vl;
            logic [35:0] trial;
            if (j == 0)
            begin
                rm = '0;
                rt = '0;
                vl = value;
            end
            else
            begin
                rm = rem_reg[j-1];
                rt = root_reg[j-1];
                vl = val_reg[j-1];
            end
            for (int s = 0; s < STEPS; s++)
            begin
                rm = {rm[33:0], vl[63:62]};
                vl = {vl[61:0], 2'b00};
                trial = {2'b00, rt, 2'b01};
                if (rm >= trial)
                begin
                    rm = rm - trial;
                    rt = {rt[30:0], 1'b1};
                end
                else
                begin
                    rt = {rt[30:0], 1'b0};
                end
            end
            rem_next[j]  = rm;
            root_next[j] = rt;
            val_next[j]  = vl;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                val_reg[j]  <= val_next[j];
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1][28:0];

endmodule

`default_nettype wire

>>> src/dielectric_refract_or_reflect_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Dielectric surface response. Takes one ray hit per cycle and returns the new direction
// (Snell refraction, or mirror reflection on total internal reflection), the tinted colour
// and a refracted flag. The pipeline has eight arithmetic stages and two 8-stage
// square-root units; a stall at the output holds every stage. Writing the index register
// starts a bit-serial reciprocal, during which no hit and no configuration write is taken;
// tint writes take effect at once.

module dielectric_refract_or_reflect_unit
    import drdr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // dir_x, dir_y, dir_z, normal_x, normal_y, normal_z, color_in_r, color_in_g, color_in_b
    input  logic [143:0] s_tdata,
    // inside_req
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_dir_x, out_dir_y, out_dir_z, color_out_r, color_out_g, color_out_b
    output logic [95:0]  m_tdata,
    // refracted
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [13:0] idx_reg;
    logic [17:0] recip_reg;
    logic [15:0] tint_r_reg, tint_g_reg, tint_b_reg;
    logic        div_busy_reg;
    logic [4:0]  div_cnt_reg;
    logic [13:0] div_rem_reg;
    logic [17:0] div_q_reg;

    logic [14:0] div_rem_s;
    logic        div_ge;
    logic [17:0] div_q_next;
    logic        cfg_fire;
    logic        en;

    item_t st_a_reg, st_b_reg, st_c_reg, st_d_reg, st_e_reg, st_f_reg, st_g_reg;
    item_t st_a_next, st_b_next, st_c_next, st_d_next, st_e_next, st_f_next, st_g_next;
    item_t dl1_reg [SQRT_LAT];
    item_t dl2_reg [SQRT_LAT];

    logic        h_valid_reg;
    logic [95:0] h_data_reg;
    logic        h_refr_reg;
    logic [95:0] h_data_next;

    logic [28:0] sin_root, r_root;

    logic signed [32:0] dn_sum;
    logic signed [33:0] neg_dn;
    logic [29:0]        abs_cos;
    logic [57:0]        cos_sq;
    logic [46:0]        prod_w;
    logic [30:0]        s_w;
    logic [61:0]        s_sq;
    logic signed [48:0] rfl_m  [3];
    logic signed [67:0] comp   [3];
    logic signed [67:0] comp_r [3];
    logic signed [50:0] rfl_r  [3];

    assign en        = !h_valid_reg || m_tready;
    assign s_tready  = en && !div_busy_reg;
    assign cfg_ready = !div_busy_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // reciprocal of the index, one quotient bit a cycle
    assign div_rem_s  = {div_rem_reg, div_cnt_reg == DIV_LAST};
    assign div_ge     = div_rem_s >= {1'b0, idx_reg};
    assign div_q_next = {div_q_reg[16:0], div_ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= INDEX_RESET;
            recip_reg    <= RECIP_RESET;
            tint_r_reg   <= TINT_RESET;
            tint_g_reg   <= TINT_RESET;
            tint_b_reg   <= TINT_RESET;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_rem_reg  <= '0;
            div_q_reg    <= '0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg_index)
                    REG_INDEX:
                    begin
                        idx_reg      <= cfg_data[13:0];
                        div_busy_reg <= 1'b1;
                        div_cnt_reg  <= DIV_LAST;
                        div_rem_reg  <= '0;
                        div_q_reg    <= '0;
                    end
                    REG_TINT_RED:   tint_r_reg <= cfg_data;
                    REG_TINT_GREEN: tint_g_reg <= cfg_data;
                    REG_TINT_BLUE:  tint_b_reg <= cfg_data;
                    default: ;
                endcase
            end
            else if (div_busy_reg)
            begin
                div_rem_reg <= div_ge ? 14'(div_rem_s - {1'b0, idx_reg}) : div_rem_s[13:0];
                div_q_reg   <= div_q_next;
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == '0)
                begin
                    div_busy_reg <= 1'b0;
                    recip_reg    <= (idx_reg < INDEX_SAT) ? ETA_MAX : div_q_next;
                end
            end
        end
    end

    // stage a: unpack, pick ratio, tint, dot terms
    always_comb
    begin
        st_a_next       = '0;
        st_a_next.valid = s_tvalid && !div_busy_reg;
        for (int i = 0; i < 3; i++)
        begin
            st_a_next.d[i] = s_tdata[16*i +: 16];
            st_a_next.n[i] = s_tdata[48 + 16*i +: 16];
            st_a_next.p[i] = 32'($signed(s_tdata[16*i +: 16]) * $signed(s_tdata[48 + 16*i +: 16]));
        end
        st_a_next.col[0] = tint_mul(s_tdata[111:96], tint_r_reg);
        st_a_next.col[1] = tint_mul(s_tdata[127:112], tint_g_reg);
        st_a_next.col[2] = tint_mul(s_tdata[143:128], tint_b_reg);
        st_a_next.eta    = s_tuser[0] ? {idx_reg, 4'b0000} : recip_reg;
    end

    // stage b: dot product and clamped cosine
    always_comb
    begin
        st_b_next = st_a_reg;
        dn_sum = $signed({st_a_reg.p[0][31], st_a_reg.p[0]})
               + $signed({st_a_reg.p[1][31], st_a_reg.p[1]})
               + $signed({st_a_reg.p[2][31], st_a_reg.p[2]});
        neg_dn = -$signed({dn_sum[32], dn_sum});
        st_b_next.dn = dn_sum;
        if (neg_dn > COS_MAX)
            st_b_next.cosv = COS_MAX[29:0];
        else if (neg_dn < -COS_MAX)
            st_b_next.cosv = 30'(-COS_MAX);
        else
            st_b_next.cosv = neg_dn[29:0];
    end

    // stage c: sine radicand
    always_comb
    begin
        st_c_next = st_b_reg;
        abs_cos   = st_b_reg.cosv[29] ? 30'(-st_b_reg.cosv) : st_b_reg.cosv;
        cos_sq    = {29'd0, abs_cos[28:0]} * {29'd0, abs_cos[28:0]};
        st_c_next.rad = ONE56 - cos_sq[56:0];
    end

    drdr_isqrt u_sin_sqrt
    (
        .clk   (clk),
        .en    (en),
        .value ({7'd0, st_c_reg.rad}),
        .root  (sin_root)
    );

    // stage d: ratio times sine, refraction test
    always_comb
    begin
        st_d_next      = dl1_reg[SQRT_LAT-1];
        prod_w         = {29'd0, dl1_reg[SQRT_LAT-1].eta} * {18'd0, sin_root};
        st_d_next.sinv = sin_root;
        st_d_next.prod = prod_w;
        st_d_next.refr = prod_w[46:44] == 3'd0;
    end

    // stage e: refract radicand, ratio times cosine, mirror terms
    always_comb
    begin
        st_e_next = st_d_reg;
        s_w       = st_d_reg.prod[46:16];
        s_sq      = {31'd0, s_w} * {31'd0, s_w};
        st_e_next.k  = (s_sq >= ONE56_W) ? '0 : ONE56 - s_sq[56:0];
        st_e_next.ec = 49'($signed({1'b0, st_d_reg.eta}) * st_d_reg.cosv);
        for (int i = 0; i < 3; i++)
        begin
            rfl_m[i] = 49'(st_d_reg.dn * $signed(st_d_reg.n[i]));
            st_e_next.rfl[i] = {{7{st_d_reg.d[i][15]}}, st_d_reg.d[i], 28'd0}
                             - {rfl_m[i][48], rfl_m[i], 1'b0};
        end
    end

    drdr_isqrt u_k_sqrt
    (
        .clk   (clk),
        .en    (en),
        .value ({7'd0, st_e_reg.k}),
        .root  (r_root)
    );

    // stage f: normal coefficient, ratio times direction
    always_comb
    begin
        st_f_next      = dl2_reg[SQRT_LAT-1];
        st_f_next.r    = r_root;
        st_f_next.coef = $signed({5'd0, r_root, 16'd0})
                       - $signed({dl2_reg[SQRT_LAT-1].ec[48], dl2_reg[SQRT_LAT-1].ec});
        for (int i = 0; i < 3; i++)
            st_f_next.ed[i] = 35'($signed({1'b0, dl2_reg[SQRT_LAT-1].eta})
                                  * $signed(dl2_reg[SQRT_LAT-1].d[i]));
    end

    // stage g: coefficient times normal
    always_comb
    begin
        st_g_next = st_f_reg;
        for (int i = 0; i < 3; i++)
            st_g_next.cn[i] = 66'(st_f_reg.coef * $signed(st_f_reg.n[i]));
    end

    // stage h: round, saturate, select
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i]   = $signed({{5{st_g_reg.ed[i][34]}}, st_g_reg.ed[i], 28'd0})
                      - $signed({{2{st_g_reg.cn[i][65]}}, st_g_reg.cn[i]});
            comp_r[i] = comp[i] + HALF44;
            rfl_r[i]  = $signed(st_g_reg.rfl[i]) + HALF28;
            h_data_next[16*i +: 16] = st_g_reg.refr ? sat_dir(comp_r[i][67:44])
                                                    : sat_dir({rfl_r[i][50], rfl_r[i][50:28]});
            h_data_next[48 + 16*i +: 16] = st_g_reg.col[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_a_reg    <= '0;
            st_b_reg    <= '0;
            st_c_reg    <= '0;
            st_d_reg    <= '0;
            st_e_reg    <= '0;
            st_f_reg    <= '0;
            st_g_reg    <= '0;
            h_valid_reg <= 1'b0;
            h_data_reg  <= '0;
            h_refr_reg  <= 1'b0;
            for (int j = 0; j < SQRT_LAT; j++)
            begin
                dl1_reg[j] <= '0;
                dl2_reg[j] <= '0;
            end
        end
        else if (en)
        begin
            st_a_reg    <= st_a_next;
            st_b_reg    <= st_b_next;
            st_c_reg    <= st_c_next;
            st_d_reg    <= st_d_next;
            st_e_reg    <= st_e_next;
            st_f_reg    <= st_f_next;
            st_g_reg    <= st_g_next;
            h_valid_reg <= st_g_reg.valid;
            h_data_reg  <= h_data_next;
            h_refr_reg  <= st_g_reg.refr;
            dl1_reg[0]  <= st_c_reg;
            dl2_reg[0]  <= st_e_reg;
            for (int j = 1; j < SQRT_LAT; j++)
            begin
                dl1_reg[j] <= dl1_reg[j-1];
                dl2_reg[j] <= dl2_reg[j-1];
            end
        end
    end

    assign m_tvalid = h_valid_reg;
    assign m_tdata  = h_data_reg;
    assign m_tuser  = h_refr_reg;

`include "dielectric_refract_or_reflect_unit_assert.svh"

    `DRDR_ASSERT_NEXT(a_index_starts_div,
        cfg_fire && (cfg_index == REG_INDEX),
        div_busy_reg && (div_cnt_reg == DIV_LAST), "index write did not start the reciprocal")
    `DRDR_ASSERT_NEXT(a_div_runs_out, div_busy_reg && (div_cnt_reg != 5'd0),
        div_busy_reg, "reciprocal stopped early")
    `DRDR_ASSERT_HOLDS(a_dir_x_range, !m_tvalid
        || (($signed(m_tdata[15:0]) <= 16'sd16384) && ($signed(m_tdata[15:0]) >= -16'sd16384)),
        "direction x out of range")
    `DRDR_ASSERT_HOLDS(a_dir_z_range, !m_tvalid
        || (($signed(m_tdata[47:32]) <= 16'sd16384) && ($signed(m_tdata[47:32]) >= -16'sd16384)),
        "direction z out of range")

endmodule

`default_nettype wire
